/* hw/rtl/gbr_pkg.sv */
// ----------------------------------------------------------------------------
// gbr_pkg
// Shared types and constants of the gamepad button remapper.
// ----------------------------------------------------------------------------
package gbr_pkg;

  localparam int MAP_ENTRIES = 9;
  localparam int ENTRY_W     = 6;
  localparam int MAP_W       = MAP_ENTRIES * ENTRY_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CNT_W       = 5;

  localparam logic [CNT_W-1:0] COUNT_MAX  = 5'd16;
  localparam logic [CNT_W-1:0] COUNT_STEP = 5'd8;

  // Game button positions.
  localparam int BTN_SHOOT = 0;
  localparam int BTN_FOCUS = 2;
  localparam int BTN_UP    = 4;
  localparam int BTN_DOWN  = 5;
  localparam int BTN_LEFT  = 6;
  localparam int BTN_RIGHT = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS_MODE  = 3'd0,
    REG_BUTTON_MAP = 3'd1,
    REG_X_MIN      = 3'd2,
    REG_X_MAX      = 3'd3,
    REG_Y_MIN      = 3'd4,
    REG_Y_MAX      = 3'd5,
    REG_X_DEADZONE = 3'd6,
    REG_Y_DEADZONE = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic             axis_mode;
    logic [MAP_W-1:0] button_map;
    logic [15:0]      x_min;
    logic [15:0]      x_max;
    logic [15:0]      y_min;
    logic [15:0]      y_max;
    logic [14:0]      x_deadzone;
    logic [14:0]      y_deadzone;
  } cfg_t;

  typedef struct packed {
    logic plus;
    logic minus;
  } axis_dir_t;

endpackage

/* hw/rtl/gbr_cfg.sv */
// ----------------------------------------------------------------------------
// gbr_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module gbr_cfg
  import gbr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MAP_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_AXIS_MODE:  cfg_nxt.axis_mode  = cfg_wdata[0];
        REG_BUTTON_MAP: cfg_nxt.button_map = cfg_wdata;
        REG_X_MIN:      cfg_nxt.x_min      = cfg_wdata[15:0];
        REG_X_MAX:      cfg_nxt.x_max      = cfg_wdata[15:0];
        REG_Y_MIN:      cfg_nxt.y_min      = cfg_wdata[15:0];
        REG_Y_MAX:      cfg_nxt.y_max      = cfg_wdata[15:0];
        REG_X_DEADZONE: cfg_nxt.x_deadzone = cfg_wdata[14:0];
        REG_Y_DEADZONE: cfg_nxt.y_deadzone = cfg_wdata[14:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.axis_mode  <= 1'b0;
      cfg_r.button_map <= '0;
      cfg_r.x_min      <= 16'h0000;
      cfg_r.x_max      <= 16'hFFFF;
      cfg_r.y_min      <= 16'h0000;
      cfg_r.y_max      <= 16'hFFFF;
      cfg_r.x_deadzone <= '0;
      cfg_r.y_deadzone <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/gbr_axis.sv */
// ----------------------------------------------------------------------------
// gbr_axis
// Turns one axis position into its two direction bits.
// ----------------------------------------------------------------------------
module gbr_axis
  import gbr_pkg::*;
(
  input  logic               axis_mode,
  input  logic signed [16:0] pos,
  input  logic [15:0]        cal_min,
  input  logic [15:0]        cal_max,
  input  logic [14:0]        deadzone,
  output axis_dir_t          dir
);

  logic [16:0]        sum;
  logic [15:0]        mid;
  logic signed [16:0] diff;
  logic signed [16:0] diff_adj;
  logic signed [16:0] quarter;
  logic signed [18:0] mid_s;
  logic signed [18:0] quarter_s;
  logic signed [18:0] dz_s;
  logic signed [18:0] hi;
  logic signed [18:0] lo;
  logic signed [18:0] pos_s;

  always_comb begin
    sum       = {1'b0, cal_min} + {1'b0, cal_max};
    mid       = sum[16:1];
    diff      = $signed({1'b0, cal_max}) - $signed({1'b0, cal_min});
    // Divide by four rounding toward zero: bias negative values first.
    diff_adj  = diff[16] ? (diff + 17'sd3) : diff;
    quarter   = diff_adj >>> 2;
    mid_s     = $signed({3'b000, mid});
    quarter_s = $signed({{2{quarter[16]}}, quarter});
    dz_s      = $signed({4'b0000, deadzone});
    pos_s     = $signed({{2{pos[16]}}, pos});
    if (axis_mode) begin
      hi = dz_s;
      lo = -dz_s;
    end else begin
      hi = mid_s + quarter_s;
      lo = mid_s - quarter_s;
    end
    dir.plus  = pos_s > hi;
    dir.minus = pos_s < lo;
  end

endmodule

/* hw/rtl/gamepad_button_remapper.sv */
// ----------------------------------------------------------------------------
// gamepad_button_remapper
// Maps one polled pad sample per transaction onto the game button word.
// ----------------------------------------------------------------------------
// One transaction per clock is sustained while out_ready holds. A sample is
// captured in an input register, mapped and thresholded by combinational
// logic, and lands in the output register once that register is free.
// The output register decouples the two channels: a new sample can enter
// the empty input register while an earlier result waits. The shared
// shoot/focus counter advances when a sample moves to the output register.
// ----------------------------------------------------------------------------
module gamepad_button_remapper
  import gbr_pkg::*;
#(
  parameter int PAD_BUTTONS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MAP_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_poll_ok,
  input  logic [31:0]          in_raw_buttons,
  input  logic signed [16:0]   in_axis_x,
  input  logic signed [16:0]   in_axis_y,
  input  logic [15:0]          in_held_buttons,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          out_game_buttons
);

  localparam logic [5:0] PAD_LIMIT = 6'(PAD_BUTTONS);

  cfg_t      cfg;
  axis_dir_t dir_x;
  axis_dir_t dir_y;

  logic               s1_valid_r;
  logic               poll_ok_r;
  logic [31:0]        raw_r;
  logic signed [16:0] ax_r;
  logic signed [16:0] ay_r;
  logic [15:0]        held_r;

  logic             out_valid_r;
  logic [15:0]      out_buttons_r;
  logic [15:0]      result_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  logic                             s2_ready;
  logic                             xfer;
  logic [MAP_ENTRIES-1:0]           pressed;
  logic [ENTRY_W-1:0]               entry [MAP_ENTRIES];
  logic                             shared;

  gbr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gbr_axis u_axis_x (
    .axis_mode (cfg.axis_mode),
    .pos       (ax_r),
    .cal_min   (cfg.x_min),
    .cal_max   (cfg.x_max),
    .deadzone  (cfg.x_deadzone),
    .dir       (dir_x)
  );

  gbr_axis u_axis_y (
    .axis_mode (cfg.axis_mode),
    .pos       (ay_r),
    .cal_min   (cfg.y_min),
    .cal_max   (cfg.y_max),
    .deadzone  (cfg.y_deadzone),
    .dir       (dir_y)
  );

  assign s2_ready = !out_valid_r || out_ready;
  assign xfer     = s1_valid_r && s2_ready;
  assign in_ready = !s1_valid_r || s2_ready;

  // An entry counts as pressed only when enabled and its index is on the pad.
  always_comb begin
    for (int k = 0; k < MAP_ENTRIES; k++) begin
      entry[k]   = cfg.button_map[k*ENTRY_W +: ENTRY_W];
      pressed[k] = !entry[k][5] && ({1'b0, entry[k][4:0]} < PAD_LIMIT) &&
                   raw_r[entry[k][4:0]];
    end
  end

  assign shared = (entry[0] == entry[2]);

  always_comb begin
    result_nxt = held_r;
    cnt_nxt    = cnt_r;
    if (poll_ok_r) begin
      for (int k = 0; k < MAP_ENTRIES; k++) begin
        if (k != BTN_FOCUS && pressed[k]) begin
          result_nxt[k] = 1'b1;
        end
      end
      if (!shared) begin
        if (pressed[BTN_FOCUS]) begin
          result_nxt[BTN_FOCUS] = 1'b1;
        end
      end else if (pressed[BTN_SHOOT]) begin
        if (cnt_r < COUNT_MAX) begin
          cnt_nxt = cnt_r + 5'd1;
        end
        if (cnt_nxt >= COUNT_STEP) begin
          result_nxt[BTN_FOCUS] = 1'b1;
        end
      end else begin
        cnt_nxt = (cnt_r > COUNT_STEP) ? (cnt_r - COUNT_STEP) : '0;
      end
      if (dir_x.plus)  result_nxt[BTN_RIGHT] = 1'b1;
      if (dir_x.minus) result_nxt[BTN_LEFT]  = 1'b1;
      if (dir_y.plus)  result_nxt[BTN_DOWN]  = 1'b1;
      if (dir_y.minus) result_nxt[BTN_UP]    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
      if (xfer) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      poll_ok_r <= in_poll_ok;
      raw_r     <= in_raw_buttons;
      ax_r      <= in_axis_x;
      ay_r      <= in_axis_y;
      held_r    <= in_held_buttons;
    end
    if (xfer) begin
      out_buttons_r <= result_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_game_buttons = out_buttons_r;

  a_cnt_saturates : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= COUNT_MAX)
    else $error("shared focus counter exceeded its ceiling");

  a_cnt_moves_on_xfer : assert property (@(posedge clk) disable iff (!rst_n)
    !xfer |=> $stable(cnt_r))
    else $error("shared focus counter changed without a transaction");

  a_failed_poll_passes_held : assert property (@(posedge clk) disable iff (!rst_n)
    xfer && !poll_ok_r |=> out_valid_r && (out_buttons_r == $past(held_r)))
    else $error("failed poll did not pass the held buttons through");

  a_failed_poll_keeps_cnt : assert property (@(posedge clk) disable iff (!rst_n)
    xfer && !poll_ok_r |=> $stable(cnt_r))
    else $error("failed poll changed the shared focus counter");

  a_empty_stage_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled while the input register was empty");

endmodule

/* sim/gbr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbr_checker
// Follows the register writes and both channels of the button remapper,
// predicts each game button word and compares it with the one delivered.
// ----------------------------------------------------------------------------
module gbr_checker
  import gbr_pkg::*;
#(
  parameter int PAD_BUTTONS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MAP_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_poll_ok,
  input  logic [31:0]          in_raw_buttons,
  input  logic signed [16:0]   in_axis_x,
  input  logic signed [16:0]   in_axis_y,
  input  logic [15:0]          in_held_buttons,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [15:0]          out_game_buttons,
  output int                   mismatches,
  output int                   outstanding,
  output int                   results_seen
);

  cfg_t             shadow_cfg;
  logic [CNT_W-1:0] focus_hold_count;
  logic [15:0]      pending_words_q[$];
  logic [15:0]      want_word;

  function automatic logic [ENTRY_W-1:0] map_entry(input int k);
    return shadow_cfg.button_map[k*ENTRY_W +: ENTRY_W];
  endfunction

  function automatic logic entry_hit(input logic [ENTRY_W-1:0] entry,
                                     input logic [31:0] raw);
    if (entry[ENTRY_W-1]) return 1'b0;
    if (int'(entry[4:0]) >= PAD_BUTTONS) return 1'b0;
    return raw[entry[4:0]];
  endfunction

  function automatic axis_dir_t axis_direction(input logic signed [16:0] pos,
                                               input logic [15:0] lo_cal, hi_cal,
                                               input logic [14:0] dz);
    int        mid;
    int        quarter;
    int        upper;
    int        lower;
    axis_dir_t dir;
    if (shadow_cfg.axis_mode == 1'b0) begin
      // Inverted calibration makes the quarter negative, swapping the bounds.
      mid     = (int'(lo_cal) + int'(hi_cal)) >>> 1;
      quarter = (int'(hi_cal) - int'(lo_cal)) / 4;
      upper   = mid + quarter;
      lower   = mid - quarter;
    end else begin
      upper = int'(dz);
      lower = -int'(dz);
    end
    dir.plus  = (int'(pos) > upper);
    dir.minus = (int'(pos) < lower);
    return dir;
  endfunction

  // Advances the shared shoot/focus counter as a side effect.
  function automatic logic [15:0] predict_buttons(input logic poll_ok,
                                                  input logic [31:0] raw,
                                                  input logic signed [16:0] ax, ay,
                                                  input logic [15:0] held);
    logic [15:0] word;
    logic        shoot_on;
    axis_dir_t   xd;
    axis_dir_t   yd;
    word = held;
    if (!poll_ok) return held;
    shoot_on = entry_hit(map_entry(BTN_SHOOT), raw);
    word[BTN_SHOOT] = word[BTN_SHOOT] | shoot_on;
    if (map_entry(BTN_SHOOT) != map_entry(BTN_FOCUS)) begin
      word[BTN_FOCUS] = word[BTN_FOCUS] | entry_hit(map_entry(BTN_FOCUS), raw);
    end else if (shoot_on) begin
      if (focus_hold_count < COUNT_MAX) focus_hold_count = focus_hold_count + 1'b1;
      if (focus_hold_count >= COUNT_STEP) word[BTN_FOCUS] = 1'b1;
    end else if (focus_hold_count > COUNT_STEP) begin
      focus_hold_count = focus_hold_count - COUNT_STEP;
    end else begin
      focus_hold_count = '0;
    end
    for (int k = 0; k < MAP_ENTRIES; k++) begin
      if (k != BTN_SHOOT && k != BTN_FOCUS) word[k] = word[k] | entry_hit(map_entry(k), raw);
    end
    xd = axis_direction(ax, shadow_cfg.x_min, shadow_cfg.x_max, shadow_cfg.x_deadzone);
    yd = axis_direction(ay, shadow_cfg.y_min, shadow_cfg.y_max, shadow_cfg.y_deadzone);
    word[BTN_RIGHT] = word[BTN_RIGHT] | xd.plus;
    word[BTN_LEFT]  = word[BTN_LEFT] | xd.minus;
    word[BTN_DOWN]  = word[BTN_DOWN] | yd.plus;
    word[BTN_UP]    = word[BTN_UP] | yd.minus;
    return word;
  endfunction

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_cfg       = '0;
      shadow_cfg.x_max = 16'hFFFF;
      shadow_cfg.y_max = 16'hFFFF;
      focus_hold_count = '0;
      pending_words_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_AXIS_MODE:  shadow_cfg.axis_mode  = cfg_wdata[0];
          REG_BUTTON_MAP: shadow_cfg.button_map = cfg_wdata;
          REG_X_MIN:      shadow_cfg.x_min      = cfg_wdata[15:0];
          REG_X_MAX:      shadow_cfg.x_max      = cfg_wdata[15:0];
          REG_Y_MIN:      shadow_cfg.y_min      = cfg_wdata[15:0];
          REG_Y_MAX:      shadow_cfg.y_max      = cfg_wdata[15:0];
          REG_X_DEADZONE: shadow_cfg.x_deadzone = cfg_wdata[14:0];
          REG_Y_DEADZONE: shadow_cfg.y_deadzone = cfg_wdata[14:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_words_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: unexpected game_buttons %04h", $realtime,
                     out_game_buttons);
        end else begin
          want_word = pending_words_q.pop_front();
          if (out_game_buttons !== want_word) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at %0t: game_buttons expected %04h, got %04h",
                       $realtime, want_word, out_game_buttons);
          end
        end
      end
      if (in_valid && in_ready)
        pending_words_q.push_back(predict_buttons(in_poll_ok, in_raw_buttons, in_axis_x,
                                                  in_axis_y, in_held_buttons));
    end
    outstanding = pending_words_q.size();
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pad samples and register settings into the button remapper with
// random gaps and output stalls; a checker beside the block scores results.
// ----------------------------------------------------------------------------
module testbench;
  import gbr_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_SAMPLES = 1920;
  localparam int SETTING_ROUNDS = 12;

  logic                 clk;
  logic                 rst_n           = 1'b0;
  logic                 cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = '0;
  logic [MAP_W-1:0]     cfg_wdata       = '0;
  logic                 in_valid        = 1'b0;
  logic                 in_ready;
  logic                 in_poll_ok      = 1'b0;
  logic [31:0]          in_raw_buttons  = '0;
  logic signed [16:0]   in_axis_x       = '0;
  logic signed [16:0]   in_axis_y       = '0;
  logic [15:0]          in_held_buttons = '0;
  logic                 out_valid;
  logic                 out_ready       = 1'b0;
  logic [15:0]          out_game_buttons;

  int mismatches;
  int outstanding;
  int results_seen;
  int samples_sent    = 0;
  int settings_loaded = 0;
  int idle_cycles     = 0;
  bit tx_steady       = 1'b0;
  bit rx_steady       = 1'b0;
  bit rx_hold_req     = 1'b0;

  gamepad_button_remapper #(.PAD_BUTTONS(32)) u_dut (.*);

  gbr_checker #(.PAD_BUTTONS(32)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [16:0] axis_sample(input logic [15:0] lo_cal, hi_cal,
                                                     input logic [14:0] dz);
    int boundary;
    case ($urandom_range(0, 4))
      0: boundary = $urandom_range(0, 17'h1FFFF);
      1: begin
        case ($urandom_range(0, 5))
          0: boundary = 17'h0FFFF;
          1: boundary = 17'h10000;
          2: boundary = 17'h00000;
          3: boundary = 17'h1FFFF;
          4: boundary = 17'h07FFF;
          default: boundary = 17'h18000;
        endcase
      end
      2: boundary = ($urandom_range(0, 1) ? int'(dz) : -int'(dz))
                    + int'($urandom_range(0, 2)) - 1;
      3: boundary = ((int'(lo_cal) + int'(hi_cal)) >>> 1)
                    + ($urandom_range(0, 1) ? 1 : -1) * ((int'(hi_cal) - int'(lo_cal)) / 4)
                    + int'($urandom_range(0, 2)) - 1;
      default: boundary = $urandom_range(0, 16'hFFFF);
    endcase
    return boundary[16:0];
  endfunction

  function automatic cfg_t random_settings();
    cfg_t               c;
    logic [ENTRY_W-1:0] entry;
    c.axis_mode = 1'($urandom_range(0, 1));
    for (int k = 0; k < MAP_ENTRIES; k++) begin
      entry    = 6'($urandom_range(0, 63));
      entry[5] = ($urandom_range(0, 6) == 0);
      c.button_map[k*ENTRY_W +: ENTRY_W] = entry;
    end
    if ($urandom_range(0, 1))
      c.button_map[BTN_FOCUS*ENTRY_W +: ENTRY_W] = c.button_map[BTN_SHOOT*ENTRY_W +: ENTRY_W];
    case ($urandom_range(0, 3))
      0: begin
        c.x_min = 16'h0000; c.x_max = 16'hFFFF; c.y_min = 16'h0000; c.y_max = 16'hFFFF;
      end
      1: begin
        c.x_min = 16'($urandom); c.x_max = 16'($urandom);
        c.y_min = 16'($urandom); c.y_max = 16'($urandom);
      end
      2: begin
        c.x_min = 16'($urandom_range(0, 16'h3FFF));
        c.x_max = 16'($urandom_range(16'hC000, 16'hFFFF));
        c.y_min = 16'($urandom_range(0, 16'h3FFF));
        c.y_max = 16'($urandom_range(16'hC000, 16'hFFFF));
      end
      default: begin
        c.x_min = 16'hFFFF; c.x_max = 16'h0000; c.y_min = 16'($urandom); c.y_max = c.y_min;
      end
    endcase
    case ($urandom_range(0, 3))
      0: begin c.x_deadzone = '0;       c.y_deadzone = 15'h7FFF; end
      1: begin c.x_deadzone = 15'h7FFF; c.y_deadzone = '0;       end
      2: begin c.x_deadzone = 15'($urandom); c.y_deadzone = 15'($urandom); end
      default: begin
        c.x_deadzone = 15'($urandom_range(0, 255));
        c.y_deadzone = 15'($urandom_range(0, 255));
      end
    endcase
    return c;
  endfunction

  // Leaves valid high so the next transaction can follow without a gap.
  task automatic send_sample(input logic poll_ok, input logic [31:0] raw,
                             input logic signed [16:0] ax, ay,
                             input logic [15:0] held);
    int gap;
    gap = tx_steady ? 0 : gap_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_poll_ok      <= poll_ok;
    in_raw_buttons  <= raw;
    in_axis_x       <= ax;
    in_axis_y       <= ay;
    in_held_buttons <= held;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [MAP_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t c);
    put_reg(REG_AXIS_MODE, MAP_W'(c.axis_mode));
    put_reg(REG_BUTTON_MAP, c.button_map);
    put_reg(REG_X_MIN, MAP_W'(c.x_min));
    put_reg(REG_X_MAX, MAP_W'(c.x_max));
    put_reg(REG_Y_MIN, MAP_W'(c.y_min));
    put_reg(REG_Y_MAX, MAP_W'(c.y_max));
    put_reg(REG_X_DEADZONE, MAP_W'(c.x_deadzone));
    put_reg(REG_Y_DEADZONE, MAP_W'(c.y_deadzone));
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // The long hold-off is counted here so the sender keeps pushing meanwhile.
  initial begin
    int stall_left;
    stall_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall_left  = 63;
        out_ready <= 1'b0;
      end else if (!rx_steady && $urandom_range(0, 99) < 30) begin
        stall_left = gap_cycles();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cfg_t               c;
    logic [31:0]        raw;
    logic [4:0]         shoot_pad;
    int                 run_left;
    bit                 press_run;
    logic signed [16:0] sweep [9];
    run_left  = 0;
    press_run = 1'b0;
    sweep = '{17'h0FFFF, 17'h00000, 17'h10000, 17'h1FFFF, 17'd49150,
              17'd49151, 17'd16384, 17'd16383, 17'd32767};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset map points every entry at pad button 0, so shoot and focus share it.
    send_sample(1'b0, 32'hFFFF_FFFF, 17'h0FFFF, 17'h10000, 16'hFFFF);
    send_sample(1'b0, 32'h0, 17'h0, 17'h0, 16'h0);
    for (int i = 0; i < 9; i++)
      send_sample(1'b1, 32'h1, sweep[i], sweep[8-i], 16'h0);
    send_sample(1'b1, 32'hFFFF_FFFE, 17'h0, 17'h0, 16'h0);
    send_sample(1'b1, 32'h1, 17'd32767, 17'd32767, 16'h0);
    wait_drained();

    // Separate focus, disabled entries and signed axes with no deadzone.
    c = '0;
    c.axis_mode  = 1'b1;
    c.button_map = {6'd0, 6'd30, 6'h3F, 6'd2, 6'd1, 6'd16, 6'd5, 6'h23, 6'd31};
    c.x_max      = 16'hFFFF;
    c.y_max      = 16'hFFFF;
    load_settings(c);
    send_sample(1'b1, 32'hFFFF_FFFF, 17'h0, 17'h0, 16'h0);
    send_sample(1'b1, 32'h0, 17'h00001, 17'h1FFFF, 16'h0);
    send_sample(1'b1, 32'hAAAA_5555, 17'h1FFFF, 17'h00001, 16'h0);
    send_sample(1'b1, 32'h5555_AAAA, 17'h10000, 17'h0FFFF, 16'h0);
    send_sample(1'b0, 32'hFFFF_FFFF, 17'h10000, 17'h0FFFF, 16'hFFFF);
    wait_drained();

    c.x_deadzone = 15'h7FFF;
    c.y_deadzone = 15'h7FFF;
    load_settings(c);
    send_sample(1'b1, 32'h0, 17'd32767, -17'sd32767, 16'h0);
    send_sample(1'b1, 32'h0, 17'd32768, -17'sd32768, 16'h0);
    send_sample(1'b1, 32'h0, -17'sd32767, 17'd32767, 16'h0);
    send_sample(1'b1, 32'h0, -17'sd32768, 17'd32768, 16'h0);
    wait_drained();

    // Inverted horizontal calibration and a zero-span vertical one, all entries off.
    c            = '0;
    c.button_map = '1;
    c.x_min      = 16'hFFFF;
    c.x_max      = 16'h0000;
    c.y_min      = 16'h8000;
    c.y_max      = 16'h8000;
    load_settings(c);
    send_sample(1'b1, 32'hFFFF_FFFF, 17'd32767, 17'd32768, 16'h0);
    send_sample(1'b1, 32'hFFFF_FFFF, 17'd50000, 17'd32769, 16'h0);
    wait_drained();

    for (int round = 0; round < SETTING_ROUNDS; round++) begin
      c = random_settings();
      load_settings(c);
      tx_steady   = (round % 4 == 1);
      rx_steady   = (round % 4 == 2);
      rx_hold_req = (round == 3 || round == 8);
      shoot_pad   = c.button_map[BTN_SHOOT*ENTRY_W +: 5];
      for (int n = 0; n < RANDOM_SAMPLES / SETTING_ROUNDS; n++) begin
        // Runs of held or released shoot exercise the shared focus counter.
        if (run_left == 0) begin
          run_left  = $urandom_range(1, 20);
          press_run = 1'($urandom_range(0, 1));
        end
        run_left--;
        raw = $urandom;
        case ($urandom_range(0, 19))
          0: raw = '0;
          1: raw = '1;
          default: ;
        endcase
        raw[shoot_pad] = press_run;
        send_sample(($urandom_range(0, 9) != 0), raw,
                    axis_sample(c.x_min, c.x_max, c.x_deadzone),
                    axis_sample(c.y_min, c.y_max, c.y_deadzone),
                    $urandom_range(0, 1) ? 16'h0 : 16'($urandom));
        if (round == 5 && n == 80) wait_drained();
      end
      wait_drained();
    end

    $display("summary: %0d results checked from %0d samples under %0d register settings",
             results_seen, samples_sent, settings_loaded);
    $display("summary: both axis modes, shared and split shoot/focus, failed polls, stalls");
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
